@@ src/assert_macros.svh @@
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ src/prfe_pkg.sv @@
// package for the partition refinement engine: constants, codes, types
// no dependencies
package prfe_pkg;

  localparam int NUM_STATES  = 32;
  localparam int MAX_CLASSES = (NUM_STATES < 32) ? NUM_STATES : 32;
  localparam logic [31:0] VALID_MASK =
    (NUM_STATES >= 32) ? 32'hFFFF_FFFF : (32'hFFFF_FFFF >> (32 - NUM_STATES));

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_REFINE = 2'd1;
  localparam logic [1:0] ACT_SORT   = 2'd2;

  localparam logic [1:0] KIND_SPLIT  = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD_COS, ST_EMIT_DONE,
    ST_RF_SCAN, ST_RF_CLS, ST_RF_MEM, ST_RF_WNEW, ST_RF_COS, ST_RF_EMIT,
    ST_SO_SCAN, ST_SO_CLS, ST_SO_MEM, ST_SO_COS, ST_SO_CPR, ST_SO_CPW
  } state_t;

  typedef struct packed {
    logic        cut;
    logic [31:0] keep;
    logic [31:0] moved;
  } split_t;

endpackage

@@ src/prfe_split.sv @@
// splits one class bitmap by a splitter mask, larger part kept
// depends on prfe_pkg
module prfe_split (
  input  logic [31:0]     members,
  input  logic [31:0]     splitter,
  output prfe_pkg::split_t res
);

  logic [31:0] out_part;
  logic [31:0] in_part;
  logic [5:0]  pop_out;
  logic [5:0]  pop_in;

  always_comb begin
    out_part = members & ~splitter;
    in_part  = members & splitter;
    pop_out  = 6'($countones(out_part));
    pop_in   = 6'($countones(in_part));
    res.cut  = (out_part != 32'd0);
    // the part outside the splitter wins ties
    if (pop_out < pop_in) begin
      res.keep  = in_part;
      res.moved = out_part;
    end else begin
      res.keep  = out_part;
      res.moved = in_part;
    end
  end

endmodule

@@ src/partition_refinement_engine.sv @@
// partition refinement engine: one request at a time, state in block memories.
// an accepted load walks the 32 states, a rejected load or unknown action goes straight
// to the done result; refine and sort scan the 32 states; output stalls hold the engine.
// reset clears the class count, assigned states and handshake state; memory
// contents stay undefined and are only read once written.
`include "assert_macros.svh"
module partition_refinement_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] set_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [4:0]  class_number,
  output logic [5:0]  class_count,
  output logic        last
);

  prfe_pkg::state_t state, state_next;

  logic [31:0] members [32];
  logic [31:0] fresh   [32];
  logic [4:0]  cos     [32];
  logic [31:0] members_q, fresh_q;
  logic [4:0]  cos_q;

  logic        mem_we;
  logic [4:0]  mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;
  logic        cos_we, fresh_we;

  logic [31:0] assigned;
  logic [5:0]  num_classes;
  logic [31:0] work_mask;
  logic [31:0] moved_r;
  logic [4:0]  s, t, cls_c, wr_cls;
  logic [5:0]  nxt, j;
  logic [1:0]  emit_kind;
  logic [4:0]  emit_num;

  logic        accept, out_free, out_load;
  logic [31:0] ld_mask;
  logic        ld_ok, do_split, is_min;
  prfe_pkg::split_t split;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != prfe_pkg::ST_IDLE);
  assign ld_mask  = set_bits & prfe_pkg::VALID_MASK & ~assigned;
  assign ld_ok    = (ld_mask != 32'd0) && (num_classes < 6'(prfe_pkg::MAX_CLASSES));
  assign do_split = split.cut && (num_classes < 6'd32);
  // smallest member test: nothing below s, s itself present
  assign is_min   = ((members_q & ((32'd2 << s) - 32'd1)) == (32'd1 << s));

  prfe_split u_split (
    .members  (members_q),
    .splitter (work_mask),
    .res      (split)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      members[mem_waddr] <= mem_wdata;
    end
    members_q <= members[mem_raddr];
    if (cos_we) begin
      cos[t] <= wr_cls;
    end
    cos_q <= cos[s];
    if (fresh_we) begin
      fresh[nxt[4:0]] <= members_q;
    end
    fresh_q <= fresh[j[4:0]];
  end

  always_comb begin
    state_next = state;
    case (state)
      prfe_pkg::ST_IDLE: begin
        if (accept) begin
          case (action)
            prfe_pkg::ACT_LOAD:   state_next = ld_ok ? prfe_pkg::ST_LD_COS
                                                     : prfe_pkg::ST_EMIT_DONE;
            prfe_pkg::ACT_REFINE: state_next = prfe_pkg::ST_RF_SCAN;
            prfe_pkg::ACT_SORT:   state_next = prfe_pkg::ST_SO_SCAN;
            default:              state_next = prfe_pkg::ST_EMIT_DONE;
          endcase
        end
      end
      prfe_pkg::ST_LD_COS:
        if (t == 5'd31) state_next = prfe_pkg::ST_EMIT_DONE;
      prfe_pkg::ST_EMIT_DONE:
        if (out_free) state_next = prfe_pkg::ST_IDLE;
      prfe_pkg::ST_RF_SCAN: begin
        if (work_mask[s]) state_next = prfe_pkg::ST_RF_CLS;
        else if (s == 5'd31) state_next = prfe_pkg::ST_EMIT_DONE;
      end
      prfe_pkg::ST_RF_CLS: state_next = prfe_pkg::ST_RF_MEM;
      prfe_pkg::ST_RF_MEM: begin
        if (do_split) state_next = prfe_pkg::ST_RF_WNEW;
        else if (s == 5'd31) state_next = prfe_pkg::ST_EMIT_DONE;
        else state_next = prfe_pkg::ST_RF_SCAN;
      end
      prfe_pkg::ST_RF_WNEW: state_next = prfe_pkg::ST_RF_COS;
      prfe_pkg::ST_RF_COS:
        if (t == 5'd31) state_next = prfe_pkg::ST_RF_EMIT;
      prfe_pkg::ST_RF_EMIT: begin
        if (out_free) begin
          state_next = (s == 5'd31) ? prfe_pkg::ST_EMIT_DONE : prfe_pkg::ST_RF_SCAN;
        end
      end
      prfe_pkg::ST_SO_SCAN: begin
        if (assigned[s]) state_next = prfe_pkg::ST_SO_CLS;
        else if (s == 5'd31) state_next = prfe_pkg::ST_SO_CPR;
      end
      prfe_pkg::ST_SO_CLS: state_next = prfe_pkg::ST_SO_MEM;
      prfe_pkg::ST_SO_MEM: begin
        if (is_min) state_next = prfe_pkg::ST_SO_COS;
        else if (s == 5'd31) state_next = prfe_pkg::ST_SO_CPR;
        else state_next = prfe_pkg::ST_SO_SCAN;
      end
      prfe_pkg::ST_SO_COS: begin
        if (t == 5'd31) begin
          state_next = (s == 5'd31) ? prfe_pkg::ST_SO_CPR : prfe_pkg::ST_SO_SCAN;
        end
      end
      prfe_pkg::ST_SO_CPR:
        state_next = (j == nxt) ? prfe_pkg::ST_EMIT_DONE : prfe_pkg::ST_SO_CPW;
      prfe_pkg::ST_SO_CPW: state_next = prfe_pkg::ST_SO_CPR;
      default: state_next = prfe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cls_c;
    mem_wdata = split.keep;
    mem_raddr = cos_q;
    cos_we    = 1'b0;
    fresh_we  = 1'b0;
    out_load  = 1'b0;
    case (state)
      prfe_pkg::ST_IDLE: begin
        mem_we    = accept && (action == prfe_pkg::ACT_LOAD) && ld_ok;
        mem_waddr = num_classes[4:0];
        mem_wdata = ld_mask;
      end
      prfe_pkg::ST_LD_COS, prfe_pkg::ST_RF_COS, prfe_pkg::ST_SO_COS:
        cos_we = moved_r[t];
      prfe_pkg::ST_EMIT_DONE, prfe_pkg::ST_RF_EMIT:
        out_load = out_free;
      prfe_pkg::ST_RF_MEM:
        mem_we = do_split;
      prfe_pkg::ST_RF_WNEW: begin
        mem_we    = 1'b1;
        mem_waddr = num_classes[4:0];
        mem_wdata = moved_r;
      end
      prfe_pkg::ST_SO_MEM:
        fresh_we = is_min;
      prfe_pkg::ST_SO_CPW: begin
        mem_we    = 1'b1;
        mem_waddr = j[4:0];
        mem_wdata = fresh_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= prfe_pkg::ST_IDLE;
      out_valid   <= 1'b0;
      num_classes <= 6'd0;
      assigned    <= 32'd0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == prfe_pkg::ST_IDLE && accept && action == prfe_pkg::ACT_LOAD && ld_ok) begin
        num_classes <= num_classes + 6'd1;
        assigned    <= assigned | ld_mask;
      end else if (state == prfe_pkg::ST_RF_WNEW) begin
        num_classes <= num_classes + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      prfe_pkg::ST_IDLE: begin
        s         <= 5'd0;
        t         <= 5'd0;
        nxt       <= 6'd0;
        j         <= 6'd0;
        work_mask <= set_bits & prfe_pkg::VALID_MASK & assigned;
        moved_r   <= ld_mask;
        wr_cls    <= num_classes[4:0];
        if (action == prfe_pkg::ACT_LOAD) begin
          emit_kind <= ld_ok ? prfe_pkg::KIND_DONE : prfe_pkg::KIND_REJECT;
          emit_num  <= ld_ok ? num_classes[4:0] : 5'd0;
        end else begin
          emit_kind <= prfe_pkg::KIND_DONE;
          emit_num  <= 5'd0;
        end
      end
      prfe_pkg::ST_LD_COS, prfe_pkg::ST_RF_COS:
        t <= t + 5'd1;
      prfe_pkg::ST_RF_SCAN, prfe_pkg::ST_SO_SCAN: begin
        if (!(state == prfe_pkg::ST_RF_SCAN ? work_mask[s] : assigned[s])) begin
          s <= s + 5'd1;
        end
      end
      prfe_pkg::ST_RF_CLS, prfe_pkg::ST_SO_CLS:
        cls_c <= cos_q;
      prfe_pkg::ST_RF_MEM: begin
        moved_r <= split.moved;
        if (!do_split) s <= s + 5'd1;
      end
      prfe_pkg::ST_RF_WNEW: begin
        wr_cls <= num_classes[4:0];
        t      <= 5'd0;
      end
      prfe_pkg::ST_RF_EMIT:
        if (out_free) s <= s + 5'd1;
      prfe_pkg::ST_SO_MEM: begin
        moved_r <= members_q;
        wr_cls  <= nxt[4:0];
        t       <= 5'd0;
        if (!is_min) s <= s + 5'd1;
      end
      prfe_pkg::ST_SO_COS: begin
        t <= t + 5'd1;
        if (t == 5'd31) begin
          nxt <= nxt + 6'd1;
          s   <= s + 5'd1;
        end
      end
      prfe_pkg::ST_SO_CPW:
        j <= j + 6'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      class_count <= num_classes;
      if (state == prfe_pkg::ST_RF_EMIT) begin
        kind         <= prfe_pkg::KIND_SPLIT;
        class_number <= wr_cls;
        last         <= 1'b0;
      end else begin
        kind         <= emit_kind;
        class_number <= emit_num;
        last         <= 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_count_range, clk, rst, num_classes > 6'(prfe_pkg::MAX_CLASSES))
  `ASSERT_IMPL(a_empty_no_class, clk, rst, assigned == 32'd0, num_classes == 6'd0)
  `ASSERT_IMPL(a_sort_bound, clk, rst, state == prfe_pkg::ST_SO_CPR, nxt <= num_classes)

endmodule

@@ dv/tb.sv @@
// self-checking bench for partition_refinement_engine: directed and random requests
// depends on prfe_pkg and the rtl; holds its own model of the class table
`timescale 1ns / 100ps
module tb;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] class_number;
    logic [5:0] class_count;
    logic       last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = prfe_pkg::ACT_LOAD;
  logic [31:0] set_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [4:0]  class_number;
  logic [5:0]  class_count;
  logic        last;

  // model of the partition
  logic [31:0] members [32];
  logic [4:0]  owner [32];
  logic [31:0] assigned;
  logic [5:0]  num_classes;

  result_t pending_results [$];
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int results_paced = 0;
  int splits_seen = 0;
  int max_gap = 7;
  int idle_cnt = 0;
  int stall_cnt = 0;

  partition_refinement_engine u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int popcount(logic [31:0] x);
    int n;
    n = 0;
    for (int i = 0; i < 32; i++) n += x[i];
    return n;
  endfunction

  function automatic void push_result(logic [1:0] k, logic [4:0] num, logic l);
    result_t r;
    r.kind = k;
    r.class_number = num;
    r.class_count = num_classes;
    r.last = l;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void predict(logic [1:0] act, logic [31:0] bits);
    logic [31:0] m, f, keep, moved, mask;
    logic [31:0] fresh [32];
    logic [4:0]  c;
    int nxt;
    case (act)
      prfe_pkg::ACT_LOAD: begin
        m = bits & prfe_pkg::VALID_MASK & ~assigned;
        if (m == 0 || num_classes >= prfe_pkg::MAX_CLASSES) begin
          push_result(prfe_pkg::KIND_REJECT, 5'd0, 1'b1);
        end else begin
          c = num_classes[4:0];
          members[c] = m;
          for (int s = 0; s < 32; s++) if (m[s]) owner[s] = c;
          assigned |= m;
          num_classes++;
          push_result(prfe_pkg::KIND_DONE, c, 1'b1);
        end
      end
      prfe_pkg::ACT_REFINE: begin
        f = bits & prfe_pkg::VALID_MASK & assigned;
        for (int s = 0; s < 32; s++) begin
          if (f[s]) begin
            c = owner[s];
            if ((members[c] & ~f) != 0 && num_classes < 32) begin
              keep = members[c] & ~f;
              moved = members[c] & f;
              if (popcount(keep) < popcount(moved)) begin
                m = keep;
                keep = moved;
                moved = m;
              end
              members[c] = keep;
              members[num_classes[4:0]] = moved;
              for (int t = 0; t < 32; t++) if (moved[t]) owner[t] = num_classes[4:0];
              num_classes++;
              push_result(prfe_pkg::KIND_SPLIT, num_classes[4:0] - 5'd1, 1'b0);
            end
          end
        end
        push_result(prfe_pkg::KIND_DONE, 5'd0, 1'b1);
      end
      prfe_pkg::ACT_SORT: begin
        nxt = 0;
        for (int s = 0; s < 32; s++) begin
          if (assigned[s]) begin
            c = owner[s];
            m = members[c];
            mask = 32'hFFFF_FFFF >> (31 - s);
            if ((m & mask) == (32'd1 << s)) begin
              fresh[nxt] = m;
              for (int t = 0; t < 32; t++) if (m[t]) owner[t] = 5'(nxt);
              nxt++;
            end
          end
        end
        for (int s = 0; s < nxt; s++) members[s] = fresh[s];
        push_result(prfe_pkg::KIND_DONE, 5'd0, 1'b1);
      end
      default: push_result(prfe_pkg::KIND_DONE, 5'd0, 1'b1);
    endcase
  endfunction

  // one request: random gap, then hold until accepted
  task automatic send_request(logic [1:0] act, logic [31:0] bits);
    int gap;
    gap = $urandom_range(0, max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action = act;
    set_bits = bits;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict(act, bits);
    requests_sent++;
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side stall pattern, a fresh wait drawn after each result taken
  always @(negedge clk) begin
    if (results_seen != results_paced) begin
      results_paced = results_seen;
      stall_cnt = $urandom_range(0, max_gap);
    end
    if (stall_cnt > 0) begin
      out_stall <= 1'b1;
      stall_cnt = stall_cnt - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (kind == prfe_pkg::KIND_SPLIT) splits_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d class_number=%0d", kind, class_number);
        errors++;
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind);
          errors++;
        end
        if (class_number !== e.class_number) begin
          $error("class_number: expected %0d, got %0d", e.class_number, class_number);
          errors++;
        end
        if (class_count !== e.class_count) begin
          $error("class_count: expected %0d, got %0d", e.class_count, class_count);
          errors++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("partition_refinement_engine regression: fail");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  task automatic test_empty_partition;
    send_request(prfe_pkg::ACT_REFINE, 32'hFFFF_FFFF);
    send_request(prfe_pkg::ACT_SORT, 32'h0);
    send_request(ACT_NONE, 32'hFFFF_FFFF);
    send_request(prfe_pkg::ACT_LOAD, 32'h0);
  endtask

  task automatic test_load_cases;
    send_request(prfe_pkg::ACT_LOAD, 32'h0000_000F);
    send_request(prfe_pkg::ACT_LOAD, 32'h0000_000F);   // already assigned: rejected
    send_request(prfe_pkg::ACT_LOAD, 32'h0000_00FC);   // partly assigned
    send_request(prfe_pkg::ACT_LOAD, 32'h8000_0000);
  endtask

  task automatic test_equal_split;
    send_request(prfe_pkg::ACT_REFINE, 32'h0000_0033);
    send_request(prfe_pkg::ACT_REFINE, 32'h0000_000F);
    send_request(prfe_pkg::ACT_REFINE, 32'h0F00_0000); // unassigned splitter bits only
  endtask

  task automatic test_sort;
    send_request(prfe_pkg::ACT_LOAD, 32'h7FFF_0000);
    send_request(prfe_pkg::ACT_REFINE, 32'h0001_0000);
    send_request(prfe_pkg::ACT_REFINE, 32'h00FE_0000);
    send_request(prfe_pkg::ACT_SORT, 32'hFFFF_FFFF);
    send_request(ACT_NONE, 32'h0);
  endtask

  task automatic test_fill_table;
    send_request(prfe_pkg::ACT_LOAD, 32'h0000_FF00);
    send_request(prfe_pkg::ACT_LOAD, 32'hFFFF_FFFF);   // nothing new left
    send_request(prfe_pkg::ACT_REFINE, 32'hAAAA_AAAA);
    send_request(prfe_pkg::ACT_REFINE, 32'h5555_5555);
    send_request(prfe_pkg::ACT_REFINE, 32'hCCCC_CCCC);
    send_request(prfe_pkg::ACT_SORT, 32'h0);
    send_request(prfe_pkg::ACT_REFINE, 32'hFFFF_FFFF);
    send_request(prfe_pkg::ACT_REFINE, 32'hF0F0_F0F0);
    send_request(prfe_pkg::ACT_LOAD, 32'h0000_0001);   // table full or no free state
  endtask

  task automatic test_random(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      max_gap = ((i / 40) % 3 == 1) ? 0 : 7;
      sel = $urandom_range(0, 9);
      if (sel < 3) send_request(prfe_pkg::ACT_LOAD, $urandom & $urandom);
      else if (sel < 7) send_request(prfe_pkg::ACT_REFINE, $urandom);
      else if (sel < 9) send_request(prfe_pkg::ACT_SORT, $urandom);
      else send_request(ACT_NONE, $urandom);
    end
  endtask

  initial begin
    assigned = '0;
    num_classes = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_partition();
    test_load_cases();
    test_equal_split();
    test_sort();
    test_fill_table();
    test_random(300);
    @(negedge clk);
    in_valid = 1'b0;
    drain();
    repeat (200) @(posedge clk);
    $display("%0d requests sent, %0d results checked, %0d of them splits",
             requests_sent, results_seen, splits_seen);
    $display("final partition holds %0d classes", num_classes);
    if (errors == 0 && pending_results.size() == 0)
      $display("partition_refinement_engine regression: pass");
    else
      $display("partition_refinement_engine regression: fail");
    $finish;
  end

endmodule

@@ partition_refinement_engine.f @@
+incdir+src
src/prfe_pkg.sv
src/prfe_split.sv
src/partition_refinement_engine.sv
dv/tb.sv
